// File: hw/rtl/drt_pkg.sv
// shared types, constants and helper functions for the trajectory rollout core
// no dependencies
`default_nettype none

package drt_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_SPEED      = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED      = 3'd1;
  localparam logic [2:0] CFG_MAX_TURN_RATE  = 3'd2;
  localparam logic [2:0] CFG_MAX_ACCEL      = 3'd3;
  localparam logic [2:0] CFG_MAX_TURN_ACCEL = 3'd4;
  localparam logic [2:0] CFG_SPEED_SAMPLES  = 3'd5;
  localparam logic [2:0] CFG_TURN_SAMPLES   = 3'd6;
  localparam logic [2:0] CFG_STEP_COUNT     = 3'd7;

  localparam int unsigned ITER_W   = 5;   // cordic iteration index, up to 24 iterations
  localparam int unsigned ATAN_LEN = 24;

  localparam logic signed [18:0] PI_Q16      = 19'sd205887;
  localparam logic signed [19:0] TWO_PI_Q16  = 20'sd411775;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WMUL,
    ST_WLIM,
    ST_CHECK,
    ST_DIVV,
    ST_DIVW,
    ST_EMIT,
    ST_CORD,
    ST_MUL,
    ST_UPD
  } drt_state_e;

  typedef enum logic {
    AXIS_SPEED,
    AXIS_TURN
  } drt_axis_e;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              win_mul;
    logic              win_lim;
    logic              div_start;
    drt_axis_e         div_axis;
    logic              take_v;
    logic              take_w;
    logic              emit;
    logic              cord_init;
    logic              cord_iter;
    logic [ITER_W-1:0] iter;
    logic              mul;
    logic              upd;
  } drt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
    logic div_done;
    logic last;
  } drt_sts_t;

  function automatic logic signed [35:0] atan_q30(input logic [ITER_W-1:0] i);
    logic signed [35:0] r;
    unique case (i)
      5'd0:    r = 36'sd843314856;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043836;
      5'd3:    r = 36'sd133525158;
      5'd4:    r = 36'sd67021686;
      5'd5:    r = 36'sd33543515;
      5'd6:    r = 36'sd16775850;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194282;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048575;
      5'd11:   r = 36'sd524287;
      5'd12:   r = 36'sd262143;
      5'd13:   r = 36'sd131071;
      5'd14:   r = 36'sd65535;
      5'd15:   r = 36'sd32767;
      5'd16:   r = 36'sd16383;
      5'd17:   r = 36'sd8191;
      5'd18:   r = 36'sd4095;
      5'd19:   r = 36'sd2047;
      5'd20:   r = 36'sd1023;
      5'd21:   r = 36'sd511;
      5'd22:   r = 36'sd255;
      5'd23:   r = 36'sd127;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

  // full reduction of an angle into (-pi, pi], conditional subtract per power of two
  function automatic logic signed [18:0] wrap_full(input logic signed [23:0] a);
    logic [25:0] t;
    logic [25:0] m;
    t = 26'($signed({{2{a[23]}}, a}) + 26'sd13176800);  // plus 32 turns
    for (int k = 5; k >= 0; k--) begin
      m = 26'(26'd411775 << k);
      if (t >= m) begin
        t = t - m;
      end
    end
    if (t > 26'd205887) begin
      t = t - 26'd411775;
    end
    return t[18:0];
  endfunction

  // sum of two wrapped angles back into (-pi, pi]
  function automatic logic signed [18:0] wrap_pair(input logic signed [18:0] a,
                                                   input logic signed [18:0] b);
    logic signed [19:0] s;
    s = 20'(a) + 20'(b);
    if (s > 20'(PI_Q16)) begin
      s = s - TWO_PI_Q16;
    end else if (s < -20'(PI_Q16)) begin
      s = s + TWO_PI_Q16;
    end
    return s[18:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/drt_div.sv
// iterative restoring divider, one quotient bit per cycle
// uses drt_pkg only for house consistency of types
`default_nettype none

module drt_div
  import drt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [29:0] num_i,
  input  wire logic [6:0]  den_i,
  output logic             done_o,
  output logic [29:0]      quot_o
);

  logic [29:0] quot_q, quot_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [7:0]  trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[6:0], quot_q[29]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[28:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[28:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd29) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: hw/rtl/drt_ctrl.sv
// sequencing state machine for the trajectory rollout core
// depends on drt_pkg for the state enum and command/status structs
`default_nettype none

module drt_ctrl
  import drt_pkg::*;
#(
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire drt_sts_t sts_i,
  output drt_cmd_t      cmd_o
);

  drt_state_e        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              oval_q, oval_d;
  logic              out_free;

  assign out_free = !oval_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    oval_d     = oval_q && !out_ready_i;
    cmd_o      = '0;
    cmd_o.iter = iter_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WMUL;
        end
      end
      ST_WMUL: begin
        cmd_o.win_mul = 1'b1;
        state_d       = ST_WLIM;
      end
      ST_WLIM: begin
        cmd_o.win_lim = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.ok) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_axis  = AXIS_SPEED;
          state_d         = ST_DIVV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVV: begin
        if (sts_i.div_done) begin
          cmd_o.take_v    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_axis  = AXIS_TURN;
          state_d         = ST_DIVW;
        end
      end
      ST_DIVW: begin
        cmd_o.div_axis = AXIS_TURN;
        if (sts_i.div_done) begin
          cmd_o.take_w = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          oval_d     = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.cord_init = 1'b1;
            iter_d          = '0;
            state_d         = ST_CORD;
          end
        end
      end
      ST_CORD: begin
        cmd_o.cord_iter = 1'b1;
        iter_d          = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

endmodule

`default_nettype wire

// File: hw/rtl/drt_dp.sv
// datapath: limit registers, velocity window, sampling, cordic and pose integration
// depends on drt_pkg and drt_div
`default_nettype none

module drt_dp
  import drt_pkg::*;
#(
  parameter int unsigned MAX_STEPS  = 63,
  parameter int unsigned STEP_SHIFT = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic [167:0] in_data_i,
  input  wire drt_cmd_t    cmd_i,
  output drt_sts_t         sts_o,
  output logic [143:0]     out_data_o,
  output logic             out_last_o
);

  // configuration
  logic signed [23:0] min_speed_q, max_speed_q;
  logic [22:0] max_turn_rate_q, max_accel_q, max_turn_accel_q;
  logic [6:0]  speed_samples_q, turn_samples_q;
  logic [5:0]  step_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q      <= 24'sd0;
      max_speed_q      <= 24'sd65536;
      max_turn_rate_q  <= 23'd65536;
      max_accel_q      <= 23'd65536;
      max_turn_accel_q <= 23'd65536;
      speed_samples_q  <= 7'd5;
      turn_samples_q   <= 7'd5;
      step_count_q     <= 6'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MIN_SPEED:      min_speed_q      <= cfg_wdata_i;
        CFG_MAX_SPEED:      max_speed_q      <= cfg_wdata_i;
        CFG_MAX_TURN_RATE:  max_turn_rate_q  <= cfg_wdata_i[22:0];
        CFG_MAX_ACCEL:      max_accel_q      <= cfg_wdata_i[22:0];
        CFG_MAX_TURN_ACCEL: max_turn_accel_q <= cfg_wdata_i[22:0];
        CFG_SPEED_SAMPLES:  speed_samples_q  <= cfg_wdata_i[6:0];
        CFG_TURN_SAMPLES:   turn_samples_q   <= cfg_wdata_i[6:0];
        CFG_STEP_COUNT:     step_count_q     <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic signed [31:0] px_q, py_q;
  logic signed [18:0] hraw_q;
  logic signed [23:0] cv_q, cw_q;
  logic [19:0] reach_q;
  logic [5:0]  si_q, ti_q;

  logic [26:0] dv_q, dw_q;
  logic signed [28:0] vlo_q, vhi_q, wlo_q, whi_q;
  logic signed [23:0] v_q, w_q;
  logic signed [18:0] hcur_q, hout_q, wred_q;
  logic [5:0]  k_q;

  logic signed [33:0] cx_q, cy_q;
  logic signed [35:0] cz_q;
  logic        flip_q;
  logic signed [43:0] pcx_q, pcy_q;

  // window limits
  logic narrow;
  logic signed [28:0] cv_lo, cv_hi, cw_lo, cw_hi;
  logic signed [28:0] vlo_d, vhi_d, wlo_d, whi_d;
  assign narrow = (reach_q != 20'd0);
  assign cv_lo  = 29'(cv_q) - $signed({2'b00, dv_q});
  assign cv_hi  = 29'(cv_q) + $signed({2'b00, dv_q});
  assign cw_lo  = 29'(cw_q) - $signed({2'b00, dw_q});
  assign cw_hi  = 29'(cw_q) + $signed({2'b00, dw_q});

  always_comb begin
    vlo_d = 29'(min_speed_q);
    vhi_d = 29'(max_speed_q);
    wlo_d = -$signed({6'd0, max_turn_rate_q});
    whi_d = $signed({6'd0, max_turn_rate_q});
    if (narrow) begin
      if (cv_lo > vlo_d) vlo_d = cv_lo;
      if (cv_hi < vhi_d) vhi_d = cv_hi;
      if (cw_lo > wlo_d) wlo_d = cw_lo;
      if (cw_hi < whi_d) whi_d = cw_hi;
    end
  end

  // sample validity
  logic [5:0] steps;
  logic v_ok, w_ok;
  assign steps = (32'(step_count_q) > MAX_STEPS) ? 6'(MAX_STEPS) : step_count_q;
  assign v_ok  = (speed_samples_q != 7'd0) && (vhi_q >= vlo_q)
               && ({1'b0, si_q} < speed_samples_q);
  assign w_ok  = (turn_samples_q != 7'd0) && (whi_q >= wlo_q)
               && ({1'b0, ti_q} < turn_samples_q);

  assign sts_o.ok   = v_ok && w_ok && (steps != 6'd0);
  assign sts_o.last = (k_q == steps);

  // sample index division, shared by both axes
  logic signed [28:0] ax_lo, ax_hi;
  logic [23:0] diff;
  logic [5:0]  ax_idx;
  logic [6:0]  ax_n;
  logic [29:0] num;
  logic [29:0] quot;
  logic        div_done;

  always_comb begin
    if (cmd_i.div_axis == AXIS_TURN) begin
      ax_lo  = wlo_q;
      ax_hi  = whi_q;
      ax_idx = ti_q;
      ax_n   = turn_samples_q;
    end else begin
      ax_lo  = vlo_q;
      ax_hi  = vhi_q;
      ax_idx = si_q;
      ax_n   = speed_samples_q;
    end
  end

  assign diff = 24'(ax_hi - ax_lo);
  assign num  = 30'(diff) * 30'(ax_idx);

  drt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (ax_n - 7'd1),
    .done_o  (div_done),
    .quot_o  (quot)
  );
  assign sts_o.div_done = div_done;

  // division result of the axis that just finished
  logic signed [28:0] fin_lo, fin_hi, fin_mid, fin_smp;
  logic [6:0]  fin_n;
  assign fin_lo  = cmd_i.take_w ? wlo_q : vlo_q;
  assign fin_hi  = cmd_i.take_w ? whi_q : vhi_q;
  assign fin_n   = cmd_i.take_w ? turn_samples_q : speed_samples_q;
  assign fin_mid = (fin_lo + fin_hi) >>> 1;
  assign fin_smp = (fin_n == 7'd1) ? fin_mid : fin_lo + $signed({5'd0, quot[23:0]});

  // cordic
  logic signed [35:0] z0, zf;
  logic               flip0;
  logic signed [33:0] xs, ys;
  logic signed [35:0] at;
  logic signed [19:0] c20, s20;

  assign z0 = 36'(hcur_q) <<< 14;
  always_comb begin
    zf    = z0;
    flip0 = 1'b0;
    if (z0 > HALF_PI_Q30) begin
      zf    = z0 - PI_Q30;
      flip0 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      zf    = z0 + PI_Q30;
      flip0 = 1'b1;
    end
  end

  assign xs  = cx_q >>> cmd_i.iter;
  assign ys  = cy_q >>> cmd_i.iter;
  assign at  = atan_q30(cmd_i.iter);
  assign c20 = flip_q ? -20'(cx_q >>> 14) : 20'(cx_q >>> 14);
  assign s20 = flip_q ? -20'(cy_q >>> 14) : 20'(cy_q >>> 14);

  // pose update
  logic signed [43:0] dx, dy;
  logic signed [44:0] sx, sy;
  logic signed [31:0] nx, ny;
  logic signed [23:0] w_div;
  assign dx = pcx_q >>> (16 + STEP_SHIFT);
  assign dy = pcy_q >>> (16 + STEP_SHIFT);
  assign sx = 45'(px_q) + 45'(dx);
  assign sy = 45'(py_q) + 45'(dy);
  assign nx = (sx > 45'sd2147483647) ? 32'sh7fffffff :
              (sx < -45'sd2147483648) ? 32'sh80000000 : sx[31:0];
  assign ny = (sy > 45'sd2147483647) ? 32'sh7fffffff :
              (sy < -45'sd2147483648) ? 32'sh80000000 : sy[31:0];
  assign w_div = w_q >>> STEP_SHIFT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q    <= in_data_i[31:0];
      py_q    <= in_data_i[63:32];
      hraw_q  <= in_data_i[82:64];
      cv_q    <= in_data_i[106:83];
      cw_q    <= in_data_i[130:107];
      reach_q <= in_data_i[150:131];
      si_q    <= in_data_i[156:151];
      ti_q    <= in_data_i[162:157];
    end
    if (cmd_i.win_mul) begin
      dv_q <= 27'((43'(max_accel_q) * 43'(reach_q)) >> 16);
      dw_q <= 27'((43'(max_turn_accel_q) * 43'(reach_q)) >> 16);
    end
    if (cmd_i.win_lim) begin
      vlo_q <= vlo_d;
      vhi_q <= vhi_d;
      wlo_q <= wlo_d;
      whi_q <= whi_d;
    end
    if (cmd_i.take_v) begin
      v_q <= fin_smp[23:0];
    end
    if (cmd_i.take_w) begin
      w_q    <= fin_smp[23:0];
      k_q    <= '0;
      hout_q <= hraw_q;
      hcur_q <= wrap_full(24'(hraw_q));
    end
    if (cmd_i.emit) begin
      out_data_o <= {7'd0, k_q, w_q, v_q, hout_q, py_q, px_q};
      out_last_o <= (k_q == steps);
    end
    if (cmd_i.cord_init) begin
      cx_q   <= GAIN_Q30;
      cy_q   <= '0;
      cz_q   <= zf;
      flip_q <= flip0;
      wred_q <= wrap_full(w_div);
    end
    if (cmd_i.cord_iter) begin
      if (cz_q >= 36'sd0) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.mul) begin
      pcx_q <= 44'(v_q) * 44'(c20);
      pcy_q <= 44'(v_q) * 44'(s20);
    end
    if (cmd_i.upd) begin
      px_q   <= nx;
      py_q   <= ny;
      hcur_q <= wrap_pair(hcur_q, wred_q);
      hout_q <= wrap_pair(hcur_q, wred_q);
      k_q    <= k_q + 6'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dynamic_window_trajectory_rollout_core.sv
// top level of the dynamic window trajectory rollout core, depends on drt_pkg, drt_ctrl, drt_dp
// the start point follows the window limits, the check and two sample divisions; each further
// point follows the iterative cordic, a multiply and a pose update; one item at a time, a new
// one being accepted only once the last has emitted its final point or been rejected
// reset: asynchronous active low, limit registers return to their defaults
`default_nettype none

module dynamic_window_trajectory_rollout_core
  import drt_pkg::*;
#(
  parameter int unsigned MAX_STEPS    = 63,
  parameter int unsigned STEP_SHIFT   = 4,
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [23:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_x, start_y, start_heading, current_speed, current_turn_rate,
  // reach_time, speed_index, turn_index
  input  wire logic [167:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x, pos_y, heading, sample_speed, sample_turn_rate, step_number
  output logic [143:0]      m_axis_tdata,
  output logic              m_axis_tlast
);

  drt_cmd_t cmd;
  drt_sts_t sts;

  drt_ctrl #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  drt_dp #(
    .MAX_STEPS  (MAX_STEPS),
    .STEP_SHIFT (STEP_SHIFT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: bench/dynamic_window_trajectory_rollout_core_tb.sv
// testbench for dynamic_window_trajectory_rollout_core: directed and random rollouts checked
// against an in-bench fixed-point predictor; depends on drt_pkg and the core rtl
`timescale 1ns / 100ps

module dynamic_window_trajectory_rollout_core_tb;
  import drt_pkg::*;

  localparam int unsigned ROLL_MAX_STEPS = 63;
  localparam int unsigned ROLL_SHIFT     = 4;
  localparam int unsigned ROLL_ITERS     = 16;
  localparam longint      ANG_PI         = 205887;
  localparam longint      ANG_TWO_PI     = 411775;
  localparam longint      Z_HALF_PI      = 1686629713;
  localparam longint      Z_PI           = 64'sd3373259426;
  localparam longint      ROT_GAIN       = 652032874;
  localparam longint      CYCLE_LIMIT    = 3000000;
  localparam int unsigned SETTLE_CYCLES  = 200;

  localparam longint ATAN_TAB [16] = '{843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767};

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [18:0] hdg;
    logic signed [23:0] cur_v;
    logic signed [23:0] cur_w;
    logic [19:0]        reach;
    logic [5:0]         v_idx;
    logic [5:0]         w_idx;
  } pose_req_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [18:0] hdg;
    logic signed [23:0] v;
    logic signed [23:0] w;
    logic [5:0]         step;
    logic               last;
  } traj_pt_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [2:0]     cfg_addr_i = '0;
  logic [23:0]    cfg_wdata_i = '0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [167:0]   s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [143:0]   m_axis_tdata;
  logic           m_axis_tlast;

  dynamic_window_trajectory_rollout_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  traj_pt_t    pts_q[$];
  longint      lim_reg [8];
  int unsigned err_cnt = 0;
  longint      cyc = 0;
  int          burst_left = 1;
  int unsigned rx_mode = 0;
  int unsigned rx_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("dynamic_window_trajectory_rollout_core_tb: errors");
      $finish;
    end
  end

  // receiver back-pressure: free-flowing, random, or a fixed duty pattern
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 300 == 0) begin
      rx_mode <= $urandom_range(0, 2);
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= $urandom_range(0, 1);
      end
      default: begin
        m_axis_tready <= (rx_cnt % 4) != 0;
      end
    endcase
  end

  function automatic longint wrap_ang(longint a);
    longint t;
    t = a % ANG_TWO_PI;
    if (t < 0) t += ANG_TWO_PI;
    if (t > ANG_PI) t -= ANG_TWO_PI;
    return t;
  endfunction

  function automatic longint sx_of(longint v, int w);
    longint m;
    m = longint'(1) << (w - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  task automatic sin_cos(input longint th, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = th * 16384;
    x = ROT_GAIN;
    y = 0;
    flip = 0;
    if (z > Z_HALF_PI) begin
      z -= Z_PI;
      flip = 1;
    end else if (z < -Z_HALF_PI) begin
      z += Z_PI;
      flip = 1;
    end
    for (int i = 0; i < ROLL_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    x = x >>> 14;
    y = y >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic bit pick_sample(longint lo, longint hi, longint n, longint idx,
                                     output longint val);
    if (n == 0 || hi < lo || idx >= n) return 0;
    if (n == 1) val = (lo + hi) >>> 1;
    else val = lo + ((hi - lo) * idx) / (n - 1);
    return 1;
  endfunction

  function automatic longint sat32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  task automatic predict_rollout(input pose_req_t r);
    longint x, y, h, v, w, c, s, dv, dw, vlo, vhi, wlo, whi, steps;
    traj_pt_t p;
    x = r.sx;
    y = r.sy;
    vlo = sx_of(lim_reg[CFG_MIN_SPEED], 24);
    vhi = sx_of(lim_reg[CFG_MAX_SPEED], 24);
    wlo = -lim_reg[CFG_MAX_TURN_RATE];
    whi = lim_reg[CFG_MAX_TURN_RATE];
    if (r.reach > 0) begin
      dv = (lim_reg[CFG_MAX_ACCEL] * longint'(r.reach)) >>> 16;
      dw = (lim_reg[CFG_MAX_TURN_ACCEL] * longint'(r.reach)) >>> 16;
      if (r.cur_v - dv > vlo) vlo = r.cur_v - dv;
      if (r.cur_v + dv < vhi) vhi = r.cur_v + dv;
      if (r.cur_w - dw > wlo) wlo = r.cur_w - dw;
      if (r.cur_w + dw < whi) whi = r.cur_w + dw;
    end
    if (!pick_sample(vlo, vhi, lim_reg[CFG_SPEED_SAMPLES], r.v_idx, v)) return;
    if (!pick_sample(wlo, whi, lim_reg[CFG_TURN_SAMPLES], r.w_idx, w)) return;
    steps = lim_reg[CFG_STEP_COUNT];
    if (steps > ROLL_MAX_STEPS) steps = ROLL_MAX_STEPS;
    if (steps == 0) return;
    h = wrap_ang(r.hdg);
    for (longint k = 0; k <= steps; k++) begin
      if (k > 0) begin
        sin_cos(h, c, s);
        x = sat32(x + ((v * c) >>> (16 + ROLL_SHIFT)));
        y = sat32(y + ((v * s) >>> (16 + ROLL_SHIFT)));
        h = wrap_ang(h + (w >>> ROLL_SHIFT));
      end
      p.px = x;
      p.py = y;
      p.hdg = (k == 0) ? r.hdg : 19'(h);
      p.v = v;
      p.w = w;
      p.step = k;
      p.last = (k == steps);
      pts_q = {pts_q, p};
    end
  endtask

  task automatic write_limit(input logic [2:0] idx, input longint val);
    longint msk;
    msk = (idx <= CFG_MAX_SPEED) ? 64'hFFFFFF :
          (idx <= CFG_MAX_TURN_ACCEL) ? 64'h7FFFFF :
          (idx == CFG_STEP_COUNT) ? 64'h3F : 64'h7F;
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= 24'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_reg[idx] = val & msk;
  endtask

  task automatic send_pose(input pose_req_t r);
    s_axis_tdata <= {5'd0, r.w_idx, r.v_idx, r.reach, r.cur_w, r.cur_v, r.hdg, r.sy, r.sx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rollout(r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // waits for all points and a quiet period so an item with no output has finished too
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pts_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic pose_req_t mk_pose(longint x, longint y, longint h, longint cv,
                                        longint cw, longint rt, longint vi, longint wi);
    pose_req_t r;
    r.sx = x; r.sy = y; r.hdg = h; r.cur_v = cv; r.cur_w = cw;
    r.reach = rt; r.v_idx = vi; r.w_idx = wi;
    return r;
  endfunction

  function automatic longint rnd_signed(int w);
    return sx_of({$urandom(), $urandom()}, w);
  endfunction

  function automatic pose_req_t rand_pose();
    pose_req_t r;
    longint ns, nw;
    r.sx = ($urandom_range(0, 3) == 0) ? rnd_signed(32) : rnd_signed(20);
    r.sy = ($urandom_range(0, 3) == 0) ? rnd_signed(32) : rnd_signed(20);
    r.hdg = ($urandom_range(0, 7) == 0) ? rnd_signed(19)
            : longint'($urandom_range(0, 411774)) - ANG_PI;
    r.cur_v = ($urandom_range(0, 3) == 0) ? rnd_signed(24) : rnd_signed(18);
    r.cur_w = ($urandom_range(0, 3) == 0) ? rnd_signed(24) : rnd_signed(18);
    case ($urandom_range(0, 4))
      0: r.reach = 0;
      1, 2: r.reach = $urandom_range(0, 65535);
      default: r.reach = $urandom;
    endcase
    ns = lim_reg[CFG_SPEED_SAMPLES];
    nw = lim_reg[CFG_TURN_SAMPLES];
    r.v_idx = (ns > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, ns - 1) : $urandom;
    r.w_idx = (nw > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, nw - 1) : $urandom;
    return r;
  endfunction

  always @(posedge clk_i) begin
    traj_pt_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pts_q.size() == 0) begin
        $display("%0t: unexpected point, actual %h last %b", $time, m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        e = pts_q.pop_front();
        if (m_axis_tdata[31:0] !== e.px) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, e.px,
                   $signed(m_axis_tdata[31:0]));
          err_cnt++;
        end
        if (m_axis_tdata[63:32] !== e.py) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, e.py,
                   $signed(m_axis_tdata[63:32]));
          err_cnt++;
        end
        if (m_axis_tdata[82:64] !== e.hdg) begin
          $display("%0t: heading expected %0d actual %0d", $time, e.hdg,
                   $signed(m_axis_tdata[82:64]));
          err_cnt++;
        end
        if (m_axis_tdata[106:83] !== e.v) begin
          $display("%0t: sample_speed expected %0d actual %0d", $time, e.v,
                   $signed(m_axis_tdata[106:83]));
          err_cnt++;
        end
        if (m_axis_tdata[130:107] !== e.w) begin
          $display("%0t: sample_turn_rate expected %0d actual %0d", $time, e.w,
                   $signed(m_axis_tdata[130:107]));
          err_cnt++;
        end
        if (m_axis_tdata[136:131] !== e.step) begin
          $display("%0t: step_number expected %0d actual %0d", $time, e.step,
                   m_axis_tdata[136:131]);
          err_cnt++;
        end
        if (m_axis_tlast !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  // reset defaults, field extremes and out-of-range headings
  task automatic test_defaults;
    send_pose(mk_pose(0, 0, 0, 0, 0, 0, 0, 0));
    send_pose(mk_pose(2147483647, -2147483648, ANG_PI, 65536, 0, 0, 4, 4));
    send_pose(mk_pose(-2147483648, 2147483647, -ANG_PI, 0, 0, 0, 2, 1));
    send_pose(mk_pose(100000, -100000, -262144, 8388607, -8388608, 1048575, 3, 0));
    send_pose(mk_pose(-1, 1, 262143, -8388608, 8388607, 1, 1, 3));
    send_pose(mk_pose(12345, 54321, 1000, 30000, -20000, 16384, 4, 2));
    send_pose(mk_pose(0, 0, 0, 0, 0, 0, 5, 0));   // speed index past count
    send_pose(mk_pose(0, 0, 0, 0, 0, 0, 0, 63));  // turn index past count
    drain();
  endtask

  // one sample per axis takes the midpoint, one step, and the longest rollout
  task automatic test_midpoint_and_steps;
    write_limit(CFG_SPEED_SAMPLES, 1);
    write_limit(CFG_TURN_SAMPLES, 1);
    write_limit(CFG_STEP_COUNT, 1);
    write_limit(CFG_MIN_SPEED, -3);
    send_pose(mk_pose(5, 5, 205000, 0, 0, 0, 0, 0));
    send_pose(mk_pose(5, 5, 205000, 0, 0, 0, 1, 0));
    drain();
    write_limit(CFG_STEP_COUNT, 63);
    write_limit(CFG_MAX_SPEED, 8388607);
    write_limit(CFG_MIN_SPEED, 8388607);
    write_limit(CFG_MAX_TURN_RATE, 8388607);
    send_pose(mk_pose(2147400000, 2147400000, 40000, 0, 0, 0, 0, 0));
    drain();
    write_limit(CFG_MIN_SPEED, -8388608);
    write_limit(CFG_MAX_SPEED, -8388608);
    send_pose(mk_pose(-2147400000, -2147400000, -40000, 0, 0, 0, 0, 0));
    drain();
  endtask

  // empty window, zero counts and zero step count give nothing; a zero-width window emits
  task automatic test_no_output_cases;
    write_limit(CFG_MIN_SPEED, 1000);
    write_limit(CFG_MAX_SPEED, 999);
    write_limit(CFG_STEP_COUNT, 3);
    send_pose(mk_pose(0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    write_limit(CFG_MAX_SPEED, 2000);
    write_limit(CFG_MAX_ACCEL, 0);
    write_limit(CFG_MAX_TURN_ACCEL, 8388607);
    send_pose(mk_pose(0, 0, 0, 50000, 0, 65536, 0, 0));  // narrowing empties speed axis
    drain();
    write_limit(CFG_MAX_TURN_RATE, 0);
    send_pose(mk_pose(0, 0, 0, 1500, 100, 65536, 0, 0));
    drain();
    write_limit(CFG_SPEED_SAMPLES, 0);
    send_pose(mk_pose(0, 0, 0, 1500, 0, 0, 0, 0));
    drain();
    write_limit(CFG_SPEED_SAMPLES, 64);
    write_limit(CFG_TURN_SAMPLES, 0);
    send_pose(mk_pose(0, 0, 0, 1500, 0, 0, 63, 0));
    drain();
    write_limit(CFG_TURN_SAMPLES, 64);
    write_limit(CFG_STEP_COUNT, 0);
    send_pose(mk_pose(0, 0, 0, 1500, 0, 0, 63, 63));
    drain();
    write_limit(CFG_STEP_COUNT, 2);
    send_pose(mk_pose(0, 0, 0, 1500, 0, 0, 63, 63));
    drain();
  endtask

  task automatic test_random;
    longint a, b;
    for (int ph = 0; ph < 7; ph++) begin
      a = ($urandom_range(0, 2) == 0) ? rnd_signed(24) : rnd_signed(19);
      b = ($urandom_range(0, 2) == 0) ? rnd_signed(24) : rnd_signed(19);
      if (a > b && $urandom_range(0, 4) != 0) begin
        write_limit(CFG_MIN_SPEED, b);
        write_limit(CFG_MAX_SPEED, a);
      end else begin
        write_limit(CFG_MIN_SPEED, a);
        write_limit(CFG_MAX_SPEED, b);
      end
      write_limit(CFG_MAX_TURN_RATE, (ph == 0) ? 8388607 : $urandom_range(0, 500000));
      write_limit(CFG_MAX_ACCEL, (ph == 1) ? 8388607 : $urandom_range(0, 300000));
      write_limit(CFG_MAX_TURN_ACCEL, (ph == 1) ? 0 : $urandom_range(0, 300000));
      write_limit(CFG_SPEED_SAMPLES, (ph == 2) ? 64 : $urandom_range(1, 12));
      write_limit(CFG_TURN_SAMPLES, (ph == 2) ? 64 : $urandom_range(1, 12));
      write_limit(CFG_STEP_COUNT, (ph == 3) ? 63 : $urandom_range(1, 12));
      repeat (54) send_pose(rand_pose());
      drain();
    end
  endtask

  initial begin
    lim_reg[CFG_MIN_SPEED] = 0;
    lim_reg[CFG_MAX_SPEED] = 65536;
    lim_reg[CFG_MAX_TURN_RATE] = 65536;
    lim_reg[CFG_MAX_ACCEL] = 65536;
    lim_reg[CFG_MAX_TURN_ACCEL] = 65536;
    lim_reg[CFG_SPEED_SAMPLES] = 5;
    lim_reg[CFG_TURN_SAMPLES] = 5;
    lim_reg[CFG_STEP_COUNT] = 16;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_midpoint_and_steps();
    test_no_output_cases();
    test_random();
    if (err_cnt == 0) begin
      $display("dynamic_window_trajectory_rollout_core_tb: clean");
    end else begin
      $display("dynamic_window_trajectory_rollout_core_tb: errors");
    end
    $finish;
  end

endmodule
